// ===== hw/rtl/mqsb_pkg.sv =====
// package for the multi-queue shared buffer
// holds the default sizes, operation and status codes, and the item structs
package mqsb_pkg;

    localparam int MQSB_SLOTS  = 16;
    localparam int MQSB_QUEUES = 4;

    localparam int DATA_W = 32;
    localparam int QID_W  = 2;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      operation;
        logic [QID_W-1:0]         queue_id;
        logic signed [DATA_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data_out;
    } t_out_item;

    // decision of the pointer logic for one word
    typedef struct packed {
        t_status status;
        logic    push_ok;
        logic    pop_ok;
    } t_ctrl_flags;

endpackage

// ===== hw/rtl/mqsb_ram.sv =====
// generic single write port, single read port ram with registered read data
// depends on nothing
module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mqsb_ctrl.sv =====
// queue head/tail pointers, free list head, fill count and slot links
// depends on mqsb_pkg
module mqsb_ctrl #(
    parameter int SLOTS  = mqsb_pkg::MQSB_SLOTS,
    parameter int QUEUES = mqsb_pkg::MQSB_QUEUES,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  mqsb_pkg::t_op            i_op,
    input  logic [mqsb_pkg::QID_W-1:0] i_queue_id,
    output mqsb_pkg::t_ctrl_flags    o_flags,
    output logic [IDX_W-1:0]         o_slot
);
    import mqsb_pkg::*;

    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

    // slots at or above the fill count have no stored link; their next free slot is the slot index plus one
    logic [PTR_W-1:0] r_link [SLOTS];
    logic [PTR_W-1:0] r_head [QUEUES];
    logic [PTR_W-1:0] r_tail [QUEUES];
    logic [PTR_W-1:0] r_free;
    logic [PTR_W-1:0] r_fill;

    logic [PTR_W-1:0]  n_free;
    logic [PTR_W-1:0]  n_fill;
    logic [PTR_W-1:0]  n_head_q;
    logic [PTR_W-1:0]  n_tail_q;

    logic [QIDX_W-1:0] q_idx;
    logic              q_ok;
    logic [PTR_W-1:0]  head_q;
    logic [PTR_W-1:0]  tail_q;
    logic              free_ok;
    logic              head_ok;
    logic              tail_ok;
    logic              is_push;
    logic              push_ok;
    logic              pop_ok;
    logic [IDX_W-1:0]  slot;
    logic [PTR_W-1:0]  slot_ptr;
    logic [PTR_W-1:0]  nxt;
    logic              link_we;
    logic [IDX_W-1:0]  link_addr;
    logic [PTR_W-1:0]  link_data;

    always_comb begin
        q_idx    = QIDX_W'(i_queue_id);
        q_ok     = (int'(i_queue_id) < QUEUES);
        head_q   = r_head[q_idx];
        tail_q   = r_tail[q_idx];
        free_ok  = (r_free < NULL_PTR);
        head_ok  = (head_q < NULL_PTR);
        tail_ok  = (tail_q < NULL_PTR);
        is_push  = (i_op == OP_PUSH);
        push_ok  = is_push && q_ok && free_ok;
        pop_ok   = !is_push && q_ok && head_ok;
        slot     = is_push ? r_free[IDX_W-1:0] : head_q[IDX_W-1:0];
        slot_ptr = PTR_W'(slot);
        nxt      = (slot_ptr >= r_fill) ? slot_ptr + PTR_W'(1) : r_link[slot];

        n_free    = r_free;
        n_fill    = r_fill;
        n_head_q  = head_q;
        n_tail_q  = tail_q;
        link_we   = 1'b0;
        link_addr = slot;
        link_data = r_free;

        if (push_ok) begin
            n_free = nxt;
            if (r_free == r_fill) begin
                n_fill = r_fill + PTR_W'(1);
            end
            if (!head_ok) begin
                n_head_q = slot_ptr;
            end else if (tail_ok) begin
                link_we   = 1'b1;
                link_addr = tail_q[IDX_W-1:0];
                link_data = slot_ptr;
            end
            n_tail_q = slot_ptr;
        end else if (pop_ok) begin
            // the tail slot is the last one, its link is never looked at
            if (head_q == tail_q) begin
                n_head_q = NULL_PTR;
                n_tail_q = NULL_PTR;
            end else begin
                n_head_q = nxt;
            end
            link_we   = 1'b1;
            link_data = free_ok ? r_free : NULL_PTR;
            n_free    = slot_ptr;
        end

        if (is_push) begin
            o_flags.status = push_ok ? ST_OK : ST_OVERFLOW;
        end else begin
            o_flags.status = pop_ok ? ST_OK : ST_UNDERFLOW;
        end
        o_flags.push_ok = push_ok;
        o_flags.pop_ok  = pop_ok;
        o_slot          = slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
            r_fill <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= NULL_PTR;
                r_tail[i] <= NULL_PTR;
            end
        end else if (i_fire) begin
            r_free <= n_free;
            r_fill <= n_fill;
            if (push_ok || pop_ok) begin
                r_head[q_idx] <= n_head_q;
                r_tail[q_idx] <= n_tail_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && link_we) begin
            r_link[link_addr] <= link_data;
        end
    end

endmodule

// ===== hw/rtl/multi_queue_shared_buffer.sv =====
// top level of the multi-queue shared buffer: input register, pointer logic,
// slot data ram and result register; depends on mqsb_pkg, mqsb_ctrl, mqsb_ram
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// one word is taken every cycle while the result is not stalled; its result is registered in the result stage
// (the input register feeds the pointer update and data ram read, which load the result stage)
// the pointer, free list and link update of one word happens at once, when that word fires
// reset is synchronous: all queues empty, every slot on the free list, no wait
// a stalled result holds; the input register still takes one more word
module multi_queue_shared_buffer #(
    parameter int SLOTS  = mqsb_pkg::MQSB_SLOTS,
    parameter int QUEUES = mqsb_pkg::MQSB_QUEUES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mqsb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mqsb_pkg::t_out_item o_out_item
);
    import mqsb_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_ctrl_flags r_flags;

    logic              fire;
    t_ctrl_flags       flags;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] rdata;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    mqsb_ctrl #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in.operation),
        .i_queue_id (r_in.queue_id),
        .o_flags    (flags),
        .o_slot     (slot)
    );

    mqsb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (fire && flags.push_ok),
        .i_waddr (slot),
        .i_wdata (r_in.data_in),
        .i_re    (fire && flags.pop_ok),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_flags <= flags;
        end
    end

    // ram read data only moves on a new pop, so it holds through a stall
    always_comb begin
        o_out_valid         = r_out_valid;
        o_out_item.status   = r_flags.status;
        o_out_item.data_out = r_flags.pop_ok ? rdata : '0;
    end

endmodule

// ===== hw/rtl/mqsb_checker.sv =====
// port-level checks for the multi-queue shared buffer, bound to the top level
// depends on mqsb_pkg and multi_queue_shared_buffer
module mqsb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mqsb_pkg::t_out_item o_out_item
);
    import mqsb_pkg::*;

    logic       acc_in;
    logic       acc_out;
    logic [1:0] r_inflight;

    assign acc_in  = i_in_valid && o_in_ready;
    assign acc_out = o_out_valid && i_out_ready;

    // words taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 2'(acc_in) - 2'(acc_out);
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight != 2'd3)
        else $error("more than two words in flight");

    a_no_result_unasked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 2'd0) |-> !o_out_valid)
        else $error("result with no word in flight");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> (o_out_item.data_out == '0))
        else $error("failed operation with nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for multi_queue_shared_buffer: directed and random push/pop words
// checked against a linked-slot model of the queues; depends on mqsb_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mqsb_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int SLOT_CNT       = MQSB_SLOTS;
    localparam int QUEUE_CNT      = MQSB_QUEUES;
    localparam int LINK_W         = $clog2(SLOT_CNT + 1);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 300;
    localparam int MAX_PRINTED    = 100;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOT_CNT);

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // linked-slot view of the buffer
    logic signed [DATA_W-1:0] slot_word [SLOT_CNT];
    logic [LINK_W-1:0]        next_slot [SLOT_CNT];
    logic [LINK_W-1:0]        q_first   [QUEUE_CNT];
    logic [LINK_W-1:0]        q_last    [QUEUE_CNT];
    logic [LINK_W-1:0]        free_top;

    t_in_item  words_to_send [$];
    t_out_item answers_due   [$];

    int  queued_total = 0;
    int  sent_total   = 0;
    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  stall_left   = 0;
    bit  stall_req    = 1'b0;
    bit  stall_seen   = 1'b0;
    bit  in_taken     = 1'b0;

    multi_queue_shared_buffer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_out_item run_queue_op(t_in_item w);
        t_out_item         r;
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] nxt;
        int                q;
        r.status   = ST_OK;
        r.data_out = '0;
        q = int'(w.queue_id);
        if (w.operation == OP_PUSH) begin
            if (q >= QUEUE_CNT || free_top >= SLOT_CNT) begin
                r.status = ST_OVERFLOW;
            end else begin
                s = free_top;
                free_top = next_slot[s];
                if (q_first[q] >= SLOT_CNT) begin
                    q_first[q] = s;
                end else if (q_last[q] < SLOT_CNT) begin
                    next_slot[q_last[q]] = s;
                end
                next_slot[s] = NIL;
                q_last[q]    = s;
                slot_word[s] = w.data_in;
            end
        end else begin
            if (q >= QUEUE_CNT || q_first[q] >= SLOT_CNT) begin
                r.status = ST_UNDERFLOW;
            end else begin
                s   = q_first[q];
                nxt = next_slot[s];
                if (nxt < SLOT_CNT) begin
                    q_first[q] = nxt;
                end else begin
                    q_first[q] = NIL;
                    q_last[q]  = NIL;
                end
                // freed slot goes to the front of the free list
                next_slot[s] = (free_top < SLOT_CNT) ? free_top : NIL;
                free_top     = s;
                r.data_out   = slot_word[s];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatches++;
        // quiet after the first hundred
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
        end
    endtask

    task automatic add_word(t_op op, int q, logic [DATA_W-1:0] data);
        t_in_item w;
        w.operation = op;
        w.queue_id  = QID_W'(q);
        w.data_in   = data;
        words_to_send.push_back(w);
        queued_total++;
    endtask

    // bursts with a changing push share so the buffer swings from empty to full
    task automatic add_random_words(int count);
        int left;
        int burst;
        int push_pct;
        int pick;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(60, 20);
            if (burst > left) begin
                burst = left;
            end
            pick = $urandom_range(2);
            push_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
            repeat (burst) begin
                add_word(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP,
                         $urandom_range(QUEUE_CNT - 1), $urandom);
            end
            left -= burst;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (sent_total != queued_total || answers_due.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (words_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= words_to_send.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_req && !stall_seen) begin
            stall_seen  <= 1'b1;
            stall_left  <= LONG_STALL;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        in_taken = 1'b0;
        moved    = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                moved    = 1'b1;
                sent_total++;
                answers_due.push_back(run_queue_op(i_in_item));
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (answers_due.size() == 0) begin
                    report_mismatch("word with none outstanding",
                                    DATA_W'(o_out_item.data_out), '0);
                end else begin
                    want = answers_due.pop_front();
                    if (o_out_item.status !== want.status) begin
                        report_mismatch("status", DATA_W'(o_out_item.status),
                                        DATA_W'(want.status));
                    end
                    if (o_out_item.data_out !== want.data_out) begin
                        report_mismatch("data_out", o_out_item.data_out, want.data_out);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("** multi_queue_shared_buffer: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOT_CNT; i++) begin
            slot_word[i] = '0;
            next_slot[i] = (i == SLOT_CNT - 1) ? NIL : LINK_W'(i + 1);
        end
        for (int i = 0; i < QUEUE_CNT; i++) begin
            q_first[i] = NIL;
            q_last[i]  = NIL;
        end
        free_top = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver mostly stalled
        tx_idle_pct = 6;
        rx_idle_pct = 84;
        add_word(OP_POP, 0, 32'h7fff_ffff);     // underflow on empty queue
        add_word(OP_PUSH, 0, 32'h8000_0000);
        add_word(OP_PUSH, 1, 32'h7fff_ffff);
        add_word(OP_PUSH, 2, 32'hffff_ffff);
        add_word(OP_PUSH, 3, 32'h0000_0000);
        add_word(OP_POP, 3, 32'hffff_ffff);     // empties queue 3
        add_word(OP_POP, 3, 32'h0000_0000);
        add_word(OP_POP, 0, 32'h5555_5555);
        for (int i = 0; i < SLOT_CNT - 2; i++) begin
            add_word(OP_PUSH, i % QUEUE_CNT,
                     (i % 2 == 0) ? 32'h5555_5555 ^ i : 32'haaaa_aaaa ^ i);
        end
        add_word(OP_PUSH, 2, 32'h1234_5678);    // overflow, no free slot
        add_word(OP_POP, 1, 32'h0);
        add_word(OP_PUSH, 1, 32'hdead_beef);    // reuses the freed slot
        add_random_words(430);
        wait_drained();

        // the other way round
        tx_idle_pct = 84;
        rx_idle_pct = 6;
        add_random_words(430);
        wait_drained();

        // full rate, with one long receiver hold-off to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_words(440);
        stall_req = 1'b1;
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (answers_due.size() != 0) begin
            report_mismatch("words never returned", DATA_W'(answers_due.size()), '0);
        end
        if (mismatches == 0) begin
            $display("** multi_queue_shared_buffer: PASSED **");
        end else begin
            $display("** multi_queue_shared_buffer: FAILED **");
        end
        $finish;
    end

endmodule
